FILE: hw/rtl/sts_pkg.sv
// Package for the SQL token scanner. No dependencies.
// Holds scan phases, token kinds, byte codes, the classified item type, a
// byte classifier for the front part and a pair check for the back part.
package sts_pkg;

  localparam int unsigned OFFSET_BITS_DEF = 24;
  localparam int unsigned LINE_BITS_DEF   = 16;
  localparam int unsigned FIFO_DEPTH      = 4;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_SLASH,
    PH_COMMENT,
    PH_IDENT,
    PH_DOT,
    PH_NUM,
    PH_NUM_E,
    PH_NUM_EXP,
    PH_OP,
    PH_STR,
    PH_STR_ESC,
    PH_STR_QUOTE
  } sts_phase_e;

  typedef enum logic [3:0] {
    K_IDENT    = 4'd0,
    K_DQ       = 4'd1,
    K_SQ       = 4'd2,
    K_NUMBER   = 4'd3,
    K_LBRACE   = 4'd4,
    K_RBRACE   = 4'd5,
    K_LBRACKET = 4'd6,
    K_RBRACKET = 4'd7,
    K_LPAREN   = 4'd8,
    K_RPAREN   = 4'd9,
    K_COMMA    = 4'd10,
    K_COLON    = 4'd11,
    K_SEMI     = 4'd12,
    K_OTHER    = 4'd13,
    K_EOF      = 4'd14,
    K_UNTERM   = 4'd15
  } sts_kind_e;

  localparam logic [7:0] CH_NL       = 8'h0a;
  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_CR       = 8'h0d;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_BANG     = 8'h21;
  localparam logic [7:0] CH_DQUOTE   = 8'h22;
  localparam logic [7:0] CH_SQUOTE   = 8'h27;
  localparam logic [7:0] CH_LPAREN   = 8'h28;
  localparam logic [7:0] CH_RPAREN   = 8'h29;
  localparam logic [7:0] CH_PLUS     = 8'h2b;
  localparam logic [7:0] CH_COMMA    = 8'h2c;
  localparam logic [7:0] CH_MINUS    = 8'h2d;
  localparam logic [7:0] CH_DOT      = 8'h2e;
  localparam logic [7:0] CH_SLASH    = 8'h2f;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_NINE     = 8'h39;
  localparam logic [7:0] CH_COLON    = 8'h3a;
  localparam logic [7:0] CH_SEMI     = 8'h3b;
  localparam logic [7:0] CH_LT       = 8'h3c;
  localparam logic [7:0] CH_EQ       = 8'h3d;
  localparam logic [7:0] CH_GT       = 8'h3e;
  localparam logic [7:0] CH_UP_A     = 8'h41;
  localparam logic [7:0] CH_UP_E     = 8'h45;
  localparam logic [7:0] CH_UP_Z     = 8'h5a;
  localparam logic [7:0] CH_LBRACKET = 8'h5b;
  localparam logic [7:0] CH_BSLASH   = 8'h5c;
  localparam logic [7:0] CH_RBRACKET = 8'h5d;
  localparam logic [7:0] CH_UNDER    = 8'h5f;
  localparam logic [7:0] CH_LO_A     = 8'h61;
  localparam logic [7:0] CH_LO_E     = 8'h65;
  localparam logic [7:0] CH_LO_Z     = 8'h7a;
  localparam logic [7:0] CH_LBRACE   = 8'h7b;
  localparam logic [7:0] CH_PIPE     = 8'h7c;
  localparam logic [7:0] CH_RBRACE   = 8'h7d;

  typedef struct packed {
    logic       eot;
    logic [7:0] text;
    logic       dig;
    logic       word;
    logic       blank;
    logic       nl;
    logic       quote;
    logic       slash;
    logic       dot;
    logic       opstart;
    logic       exp_e;
    logic       sign;
    logic       bslash;
    logic       punct;
    sts_kind_e  pkind;
  } sts_item_t;

  function automatic sts_item_t sts_classify(logic eot, logic [7:0] b);
    sts_item_t it;
    logic      alf;
    it.eot     = eot;
    it.text    = b;
    alf        = (b >= CH_LO_A && b <= CH_LO_Z) || (b >= CH_UP_A && b <= CH_UP_Z);
    it.dig     = (b >= CH_ZERO) && (b <= CH_NINE);
    it.word    = alf || it.dig || (b == CH_UNDER);
    it.blank   = (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
    it.nl      = (b == CH_NL);
    it.quote   = (b == CH_SQUOTE) || (b == CH_DQUOTE);
    it.slash   = (b == CH_SLASH);
    it.dot     = (b == CH_DOT);
    it.opstart = (b == CH_LT) || (b == CH_GT) || (b == CH_BANG) || (b == CH_PIPE) ||
                 (b == CH_MINUS);
    it.exp_e   = (b == CH_LO_E) || (b == CH_UP_E);
    it.sign    = (b == CH_PLUS) || (b == CH_MINUS);
    it.bslash  = (b == CH_BSLASH);
    it.punct   = 1'b1;
    it.pkind   = K_OTHER;
    unique case (b)
      CH_LBRACE:   it.pkind = K_LBRACE;
      CH_RBRACE:   it.pkind = K_RBRACE;
      CH_LBRACKET: it.pkind = K_LBRACKET;
      CH_RBRACKET: it.pkind = K_RBRACKET;
      CH_LPAREN:   it.pkind = K_LPAREN;
      CH_RPAREN:   it.pkind = K_RPAREN;
      CH_COMMA:    it.pkind = K_COMMA;
      CH_COLON:    it.pkind = K_COLON;
      CH_SEMI:     it.pkind = K_SEMI;
      default:     it.punct = 1'b0;
    endcase
    return it;
  endfunction

  function automatic logic sts_pairs(logic [7:0] a, logic [7:0] b);
    logic p;
    p = 1'b0;
    unique case (a)
      CH_LT:    p = (b == CH_EQ) || (b == CH_GT) || (b == CH_MINUS) || (b == CH_LT);
      CH_GT:    p = (b == CH_EQ) || (b == CH_GT);
      CH_BANG:  p = (b == CH_EQ);
      CH_PIPE:  p = (b == CH_PIPE);
      CH_MINUS: p = (b == CH_GT);
      default:  p = 1'b0;
    endcase
    return p;
  endfunction

endpackage

FILE: hw/rtl/sts_front.sv
// Front part of the SQL token scanner: accepts input requests and
// classifies each byte into a register stage. Depends on sts_pkg.
module sts_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              mode_i,
  input  logic [7:0]        text_byte_i,
  output logic              item_valid_o,
  output sts_pkg::sts_item_t item_o,
  input  logic              item_ready_i
);
  import sts_pkg::*;

  logic      v_q, v_d;
  sts_item_t item_q;
  logic      take;

  assign in_ready_o   = !v_q || item_ready_i;
  assign take         = in_valid_i && in_ready_o;
  assign item_valid_o = v_q;
  assign item_o       = item_q;

  always_comb begin
    v_d = v_q;
    if (take) begin
      v_d = 1'b1;
    end else if (item_ready_i) begin
      v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else begin
      v_q <= v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= sts_classify(mode_i, text_byte_i);
    end
  end

endmodule

FILE: hw/rtl/sts_fifo.sv
// Short request queue between the scanner front and back parts.
// Holds classified items; depends on sts_pkg for the item type and depth.
module sts_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  input  sts_pkg::sts_item_t push_item_i,
  output logic              push_ready_o,
  output logic              pop_valid_o,
  output sts_pkg::sts_item_t pop_item_o,
  input  logic              pop_ready_i
);
  import sts_pkg::*;

  localparam int unsigned PtrBits = $clog2(FIFO_DEPTH);
  localparam int unsigned CntBits = $clog2(FIFO_DEPTH + 1);

  sts_item_t            mem_q [FIFO_DEPTH];
  logic [PtrBits-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [CntBits-1:0]   cnt_q, cnt_d;
  logic                 push, pop;

  assign push_ready_o = (cnt_q != CntBits'(FIFO_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_item_o   = mem_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_d  = push ? wr_q + PtrBits'(1) : wr_q;
    rd_d  = pop ? rd_q + PtrBits'(1) : rd_q;
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + CntBits'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CntBits'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_item_i;
    end
  end

endmodule

FILE: hw/rtl/sts_back.sv
// Back part of the SQL token scanner: runs the token state machine on one
// queued item per cycle unless the spill slot or a held result stalls it,
// and drives the result register plus a spill slot. Depends on sts_pkg.
module sts_back #(
  parameter int unsigned OFFSET_BITS = sts_pkg::OFFSET_BITS_DEF,
  parameter int unsigned LINE_BITS   = sts_pkg::LINE_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   item_valid_i,
  input  sts_pkg::sts_item_t     item_i,
  output logic                   item_ready_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [3:0]             token_kind_o,
  output logic [OFFSET_BITS-1:0] start_offset_o,
  output logic [OFFSET_BITS-1:0] end_offset_o,
  output logic [LINE_BITS-1:0]   start_line_o,
  output logic [LINE_BITS-1:0]   start_column_o,
  output logic                   last_of_run_o
);
  import sts_pkg::*;

  localparam logic [OFFSET_BITS-1:0] OffMax  = '1;
  localparam logic [LINE_BITS-1:0]   LineMax = '1;

  sts_phase_e             phase_q, phase_d;
  logic [7:0]             held_q, held_d;
  logic [OFFSET_BITS-1:0] tb_q, tb_d, off_q, off_d;
  logic [LINE_BITS-1:0]   tl_q, tl_d, tc_q, tc_d, line_q, line_d, col_q, col_d;
  logic                   fin_q, fin_d;

  logic                   fire, take;
  logic [OFFSET_BITS-1:0] cur, nxt;
  logic                   again, close, eof_emit, begin_emit, two, any;
  sts_kind_e              close_kind, str_kind, second_kind;
  logic [OFFSET_BITS-1:0] close_end, second_end;

  sts_kind_e              r0_kind, r1_kind;
  logic [OFFSET_BITS-1:0] r0_s, r0_e;
  logic [LINE_BITS-1:0]   r0_l, r0_c;

  logic                   out_v_q, out_v_d, pend_v_q, pend_v_d;
  sts_kind_e              out_kind_q, pend_kind_q;
  logic [OFFSET_BITS-1:0] out_s_q, out_e_q, pend_s_q, pend_e_q;
  logic [LINE_BITS-1:0]   out_l_q, out_c_q, pend_l_q, pend_c_q;
  logic                   out_last_q, load_out, load_pend;

  assign take         = out_v_q && out_ready_i;
  assign item_ready_o = !pend_v_q && (!out_v_q || out_ready_i);
  assign fire         = item_valid_i && item_ready_o;

  assign cur      = off_q;
  assign nxt      = (off_q != OffMax) ? off_q + OFFSET_BITS'(1) : off_q;
  assign str_kind = (held_q == CH_SQUOTE) ? K_SQ : K_DQ;

  // classify what this item closes and whether it starts a new token
  always_comb begin
    again     = 1'b0;
    close     = 1'b0;
    close_kind = K_OTHER;
    close_end = cur;
    eof_emit  = 1'b0;
    if (item_i.eot) begin
      eof_emit = 1'b1;
      if (!fin_q) begin
        unique case (phase_q)
          PH_SLASH, PH_DOT, PH_OP: begin
            close = 1'b1;
          end
          PH_IDENT: begin
            close      = 1'b1;
            close_kind = K_IDENT;
          end
          PH_NUM, PH_NUM_E, PH_NUM_EXP: begin
            close      = 1'b1;
            close_kind = K_NUMBER;
          end
          PH_STR, PH_STR_ESC: begin
            close      = 1'b1;
            close_kind = K_UNTERM;
            eof_emit   = 1'b0;
          end
          PH_STR_QUOTE: begin
            close      = 1'b1;
            close_kind = str_kind;
          end
          default: ;
        endcase
      end
    end else if (!fin_q) begin
      unique case (phase_q)
        PH_SLASH: begin
          again = !item_i.slash;
          close = again;
        end
        PH_COMMENT: ;
        PH_IDENT: begin
          again      = !item_i.word;
          close      = again;
          close_kind = K_IDENT;
        end
        PH_DOT: begin
          again = !item_i.dig;
          close = again;
        end
        PH_NUM: begin
          again      = !item_i.exp_e && !item_i.dig && !item_i.dot;
          close      = again;
          close_kind = K_NUMBER;
        end
        PH_NUM_E: begin
          again      = !item_i.sign && !item_i.dig;
          close      = again;
          close_kind = K_NUMBER;
        end
        PH_NUM_EXP: begin
          again      = !item_i.dig;
          close      = again;
          close_kind = K_NUMBER;
        end
        PH_OP: begin
          close = 1'b1;
          again = !sts_pairs(held_q, item_i.text);
          close_end = again ? cur : nxt;
        end
        PH_STR, PH_STR_ESC: ;
        PH_STR_QUOTE: begin
          again      = (item_i.text != held_q);
          close      = again;
          close_kind = str_kind;
        end
        default: again = 1'b1;
      endcase
    end
  end

  assign begin_emit  = again && !item_i.blank &&
                       (item_i.punct || !(item_i.quote || item_i.slash || item_i.dot ||
                                          item_i.opstart || item_i.word));
  assign second_kind = eof_emit ? K_EOF : (item_i.punct ? item_i.pkind : K_OTHER);
  assign second_end  = eof_emit ? cur : nxt;
  assign two         = close && (begin_emit || eof_emit);
  assign any         = close || begin_emit || eof_emit;

  // result slots
  always_comb begin
    r1_kind = second_kind;
    if (close) begin
      r0_kind = close_kind;
      r0_s    = tb_q;
      r0_e    = close_end;
      r0_l    = tl_q;
      r0_c    = tc_q;
    end else begin
      r0_kind = second_kind;
      r0_s    = cur;
      r0_e    = second_end;
      r0_l    = line_q;
      r0_c    = col_q;
    end
  end

  // scanner next state
  always_comb begin
    phase_d = phase_q;
    held_d  = held_q;
    tb_d    = tb_q;
    tl_d    = tl_q;
    tc_d    = tc_q;
    off_d   = off_q;
    line_d  = line_q;
    col_d   = col_q;
    fin_d   = fin_q;
    if (fire) begin
      if (item_i.eot) begin
        phase_d = PH_IDLE;
        fin_d   = 1'b1;
      end else if (!fin_q) begin
        unique case (phase_q)
          PH_SLASH:     if (item_i.slash) phase_d = PH_COMMENT;
          PH_COMMENT:   if (item_i.nl) phase_d = PH_IDLE;
          PH_DOT:       if (item_i.dig) phase_d = PH_NUM;
          PH_NUM:       if (item_i.exp_e) phase_d = PH_NUM_E;
          PH_NUM_E:     if (item_i.sign || item_i.dig) phase_d = PH_NUM_EXP;
          PH_OP:        if (!again) phase_d = PH_IDLE;
          PH_STR: begin
            if (item_i.text == held_q) begin
              phase_d = PH_STR_QUOTE;
            end else if (item_i.bslash) begin
              phase_d = PH_STR_ESC;
            end
          end
          PH_STR_ESC:   phase_d = PH_STR;
          PH_STR_QUOTE: if (!again) phase_d = PH_STR;
          default: ;
        endcase
        if (again) begin
          phase_d = PH_IDLE;
          if (!item_i.blank) begin
            tb_d = cur;
            tl_d = line_q;
            tc_d = col_q;
            if (item_i.quote) begin
              phase_d = PH_STR;
              held_d  = item_i.text;
            end else if (item_i.slash) begin
              phase_d = PH_SLASH;
            end else if (item_i.dot) begin
              phase_d = PH_DOT;
            end else if (item_i.opstart) begin
              phase_d = PH_OP;
              held_d  = item_i.text;
            end else if (item_i.punct) begin
              phase_d = PH_IDLE;
            end else if (item_i.dig) begin
              phase_d = PH_NUM;
            end else if (item_i.word) begin
              phase_d = PH_IDENT;
            end
          end
        end
        if (item_i.nl) begin
          if (line_q != LineMax) line_d = line_q + LINE_BITS'(1);
          col_d = LINE_BITS'(1);
        end else if (col_q != LineMax) begin
          col_d = col_q + LINE_BITS'(1);
        end
        off_d = nxt;
      end
    end
  end

  // output register and spill slot
  always_comb begin
    out_v_d   = out_v_q;
    pend_v_d  = pend_v_q;
    load_out  = 1'b0;
    load_pend = 1'b0;
    if (pend_v_q) begin
      if (take) begin
        pend_v_d = 1'b0;
      end
    end else if (fire && any) begin
      out_v_d   = 1'b1;
      load_out  = 1'b1;
      load_pend = two;
      pend_v_d  = two;
    end else if (take) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      held_q   <= '0;
      tb_q     <= '0;
      tl_q     <= LINE_BITS'(1);
      tc_q     <= LINE_BITS'(1);
      off_q    <= '0;
      line_q   <= LINE_BITS'(1);
      col_q    <= LINE_BITS'(1);
      fin_q    <= 1'b0;
      out_v_q  <= 1'b0;
      pend_v_q <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      held_q   <= held_d;
      tb_q     <= tb_d;
      tl_q     <= tl_d;
      tc_q     <= tc_d;
      off_q    <= off_d;
      line_q   <= line_d;
      col_q    <= col_d;
      fin_q    <= fin_d;
      out_v_q  <= out_v_d;
      pend_v_q <= pend_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pend_v_q && take) begin
      out_kind_q <= pend_kind_q;
      out_s_q    <= pend_s_q;
      out_e_q    <= pend_e_q;
      out_l_q    <= pend_l_q;
      out_c_q    <= pend_c_q;
      out_last_q <= 1'b1;
    end else if (load_out) begin
      out_kind_q <= r0_kind;
      out_s_q    <= r0_s;
      out_e_q    <= r0_e;
      out_l_q    <= r0_l;
      out_c_q    <= r0_c;
      out_last_q <= !two;
    end
    if (load_pend) begin
      pend_kind_q <= r1_kind;
      pend_s_q    <= cur;
      pend_e_q    <= second_end;
      pend_l_q    <= line_q;
      pend_c_q    <= col_q;
    end
  end

  assign out_valid_o    = out_v_q;
  assign token_kind_o   = out_kind_q;
  assign start_offset_o = out_s_q;
  assign end_offset_o   = out_e_q;
  assign start_line_o   = out_l_q;
  assign start_column_o = out_c_q;
  assign last_of_run_o  = out_last_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) pend_v_q |-> out_v_q)
    else $error("spill slot full while output register empty");
  assert property (@(posedge clk_i) disable iff (!rst_ni) fin_q |=> fin_q)
    else $error("end-of-text flag cleared without reset");
  assert property (@(posedge clk_i) disable iff (!rst_ni) fin_q |-> phase_q == PH_IDLE)
    else $error("scanner left idle after end of text");
  assert property (@(posedge clk_i) disable iff (!rst_ni) pend_v_q |-> !fire)
    else $error("item consumed while a second result is pending");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (fire && !item_i.eot && fin_q) |=> $stable(off_q))
    else $error("offset advanced on text after end of text");

endmodule

FILE: hw/rtl/sql_token_scanner.sv
// SQL token scanner top level: front classifier, request queue, back scanner.
// A request that finishes a token passes the front register and a queue slot
// before its first result is loaded into the result register.
// Throughput: one byte per cycle while results are taken; a request with two
// results stalls the back part while the spill slot drains into the output.
// Reset: asynchronous, clears all control state; no clearing pass.
module sql_token_scanner #(
  parameter int unsigned OFFSET_BITS = sts_pkg::OFFSET_BITS_DEF,
  parameter int unsigned LINE_BITS   = sts_pkg::LINE_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   mode_i,
  input  logic [7:0]             text_byte_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [3:0]             token_kind_o,
  output logic [OFFSET_BITS-1:0] start_offset_o,
  output logic [OFFSET_BITS-1:0] end_offset_o,
  output logic [LINE_BITS-1:0]   start_line_o,
  output logic [LINE_BITS-1:0]   start_column_o,
  output logic                   last_of_run_o
);
  import sts_pkg::*;

  logic      fr_valid, fr_ready, bk_valid, bk_ready;
  sts_item_t fr_item, bk_item;

  sts_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .mode_i       (mode_i),
    .text_byte_i  (text_byte_i),
    .item_valid_o (fr_valid),
    .item_o       (fr_item),
    .item_ready_i (fr_ready)
  );

  sts_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_item_i  (fr_item),
    .push_ready_o (fr_ready),
    .pop_valid_o  (bk_valid),
    .pop_item_o   (bk_item),
    .pop_ready_i  (bk_ready)
  );

  sts_back #(
    .OFFSET_BITS (OFFSET_BITS),
    .LINE_BITS   (LINE_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_valid_i   (bk_valid),
    .item_i         (bk_item),
    .item_ready_o   (bk_ready),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .token_kind_o   (token_kind_o),
    .start_offset_o (start_offset_o),
    .end_offset_o   (end_offset_o),
    .start_line_o   (start_line_o),
    .start_column_o (start_column_o),
    .last_of_run_o  (last_of_run_o)
  );

endmodule

FILE: bench/tb_sql_token_scanner.sv
// Self-checking bench for sql_token_scanner: a queued byte stream drives the
// request side while a token predictor checks every result in order.
// Depends on sts_pkg (phases, kinds, byte codes) and the scanner RTL.
module tb_sql_token_scanner;
  timeunit 1ns;
  timeprecision 1ps;

  import sts_pkg::*;

  localparam int unsigned OFF_W = OFFSET_BITS_DEF;
  localparam int unsigned LN_W  = LINE_BITS_DEF;

  typedef enum logic [1:0] {
    PACE_FREE,
    PACE_SRC,
    PACE_SNK,
    PACE_BOTH
  } pace_e;

  typedef struct {
    logic       eot;
    logic [7:0] text;
    pace_e      pace;
    logic       hold;
  } text_req_t;

  typedef struct packed {
    logic [3:0]       kind;
    logic [OFF_W-1:0] s_off;
    logic [OFF_W-1:0] e_off;
    logic [LN_W-1:0]  line;
    logic [LN_W-1:0]  col;
    logic             last;
  } token_t;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  logic             in_ready;
  logic             mode_r    = 1'b0;
  logic [7:0]       byte_r    = 8'h00;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [3:0]       token_kind;
  logic [OFF_W-1:0] start_offset;
  logic [OFF_W-1:0] end_offset;
  logic [LN_W-1:0]  start_line;
  logic [LN_W-1:0]  start_column;
  logic             last_of_run;

  text_req_t text_feed[$];
  token_t    pending_tokens[$];
  pace_e     cur_pace  = PACE_FREE;
  pace_e     gen_pace  = PACE_FREE;
  logic      gen_hold  = 1'b0;
  int        gen_count = 0;
  int        mismatches = 0;
  int        results_seen = 0;

  // Scanner state mirror
  sts_phase_e       scan_ph;
  logic [7:0]       held_b;
  logic [OFF_W-1:0] tok_begin;
  logic [LN_W-1:0]  tok_line;
  logic [LN_W-1:0]  tok_col;
  logic [OFF_W-1:0] byte_pos;
  logic [LN_W-1:0]  line_cnt;
  logic [LN_W-1:0]  col_cnt;
  logic             text_done;
  token_t           run_tok[2];
  int               run_n;

  sql_token_scanner dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .mode_i         (mode_r),
    .text_byte_i    (byte_r),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .token_kind_o   (token_kind),
    .start_offset_o (start_offset),
    .end_offset_o   (end_offset),
    .start_line_o   (start_line),
    .start_column_o (start_column),
    .last_of_run_o  (last_of_run)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  function automatic logic digit_byte(input logic [7:0] b);
    return b >= CH_ZERO && b <= CH_NINE;
  endfunction

  function automatic logic alpha_byte(input logic [7:0] b);
    return (b >= CH_LO_A && b <= CH_LO_Z) || (b >= CH_UP_A && b <= CH_UP_Z);
  endfunction

  function automatic logic word_byte(input logic [7:0] b);
    return alpha_byte(b) || digit_byte(b) || b == CH_UNDER;
  endfunction

  function automatic logic blank_byte(input logic [7:0] b);
    return b == CH_SPACE || (b >= CH_TAB && b <= CH_CR);
  endfunction

  function automatic logic joins_op(input logic [7:0] a, input logic [7:0] b);
    case (a)
      CH_LT:    return b == CH_EQ || b == CH_GT || b == CH_MINUS || b == CH_LT;
      CH_GT:    return b == CH_EQ || b == CH_GT;
      CH_BANG:  return b == CH_EQ;
      CH_PIPE:  return b == CH_PIPE;
      CH_MINUS: return b == CH_GT;
      default:  return 1'b0;
    endcase
  endfunction

  function automatic logic [3:0] quoted_kind();
    return (held_b == CH_SQUOTE) ? K_SQ : K_DQ;
  endfunction

  task automatic emit_token(input logic [3:0] kind, input logic [OFF_W-1:0] s,
                            input logic [OFF_W-1:0] e, input logic [LN_W-1:0] l,
                            input logic [LN_W-1:0] c);
    run_tok[run_n] = '{kind: kind, s_off: s, e_off: e, line: l, col: c, last: 1'b0};
    run_n++;
  endtask

  task automatic emit_held(input logic [3:0] kind, input logic [OFF_W-1:0] e);
    emit_token(kind, tok_begin, e, tok_line, tok_col);
  endtask

  task automatic open_token(input logic [7:0] b, input logic [OFF_W-1:0] cur,
                            input logic [OFF_W-1:0] nxt);
    scan_ph = PH_IDLE;
    if (!blank_byte(b)) begin
      tok_begin = cur;
      tok_line  = line_cnt;
      tok_col   = col_cnt;
      case (b)
        CH_LBRACE:   emit_held(K_LBRACE, nxt);
        CH_RBRACE:   emit_held(K_RBRACE, nxt);
        CH_LBRACKET: emit_held(K_LBRACKET, nxt);
        CH_RBRACKET: emit_held(K_RBRACKET, nxt);
        CH_LPAREN:   emit_held(K_LPAREN, nxt);
        CH_RPAREN:   emit_held(K_RPAREN, nxt);
        CH_COMMA:    emit_held(K_COMMA, nxt);
        CH_COLON:    emit_held(K_COLON, nxt);
        CH_SEMI:     emit_held(K_SEMI, nxt);
        CH_SQUOTE, CH_DQUOTE: begin
          scan_ph = PH_STR;
          held_b  = b;
        end
        CH_SLASH: scan_ph = PH_SLASH;
        CH_DOT:   scan_ph = PH_DOT;
        CH_LT, CH_GT, CH_BANG, CH_PIPE, CH_MINUS: begin
          scan_ph = PH_OP;
          held_b  = b;
        end
        default: begin
          if (alpha_byte(b) || b == CH_UNDER) scan_ph = PH_IDENT;
          else if (digit_byte(b)) scan_ph = PH_NUM;
          else emit_held(K_OTHER, nxt);
        end
      endcase
    end
  endtask

  task automatic tokenize_byte(input logic eot, input logic [7:0] b);
    logic [OFF_W-1:0] cur;
    logic [OFF_W-1:0] nxt;
    logic             eof_too;
    logic             restart;
    run_n   = 0;
    cur     = byte_pos;
    nxt     = (byte_pos != {OFF_W{1'b1}}) ? byte_pos + OFF_W'(1) : byte_pos;
    eof_too = 1'b1;
    restart = 1'b0;
    if (eot) begin
      if (!text_done) begin
        case (scan_ph)
          PH_SLASH, PH_DOT, PH_OP:      emit_held(K_OTHER, cur);
          PH_IDENT:                     emit_held(K_IDENT, cur);
          PH_NUM, PH_NUM_E, PH_NUM_EXP: emit_held(K_NUMBER, cur);
          PH_STR, PH_STR_ESC: begin
            emit_held(K_UNTERM, cur);
            eof_too = 1'b0;
          end
          PH_STR_QUOTE: emit_held(quoted_kind(), cur);
          default: ;
        endcase
      end
      if (eof_too) emit_token(K_EOF, cur, cur, line_cnt, col_cnt);
      scan_ph   = PH_IDLE;
      text_done = 1'b1;
    end else if (!text_done) begin
      case (scan_ph)
        PH_SLASH: begin
          if (b == CH_SLASH) scan_ph = PH_COMMENT;
          else begin
            emit_held(K_OTHER, cur);
            restart = 1'b1;
          end
        end
        PH_COMMENT: if (b == CH_NL) scan_ph = PH_IDLE;
        PH_IDENT: begin
          if (!word_byte(b)) begin
            emit_held(K_IDENT, cur);
            restart = 1'b1;
          end
        end
        PH_DOT: begin
          if (digit_byte(b)) scan_ph = PH_NUM;
          else begin
            emit_held(K_OTHER, cur);
            restart = 1'b1;
          end
        end
        PH_NUM: begin
          if (b == CH_LO_E || b == CH_UP_E) scan_ph = PH_NUM_E;
          else if (!digit_byte(b) && b != CH_DOT) begin
            emit_held(K_NUMBER, cur);
            restart = 1'b1;
          end
        end
        PH_NUM_E: begin
          if (b == CH_PLUS || b == CH_MINUS || digit_byte(b)) scan_ph = PH_NUM_EXP;
          else begin
            emit_held(K_NUMBER, cur);
            restart = 1'b1;
          end
        end
        PH_NUM_EXP: begin
          if (!digit_byte(b)) begin
            emit_held(K_NUMBER, cur);
            restart = 1'b1;
          end
        end
        PH_OP: begin
          if (joins_op(held_b, b)) begin
            emit_held(K_OTHER, nxt);
            scan_ph = PH_IDLE;
          end else begin
            emit_held(K_OTHER, cur);
            restart = 1'b1;
          end
        end
        PH_STR: begin
          if (b == held_b) scan_ph = PH_STR_QUOTE;
          else if (b == CH_BSLASH) scan_ph = PH_STR_ESC;
        end
        PH_STR_ESC: scan_ph = PH_STR;
        PH_STR_QUOTE: begin
          if (b == held_b) scan_ph = PH_STR;
          else begin
            emit_held(quoted_kind(), cur);
            restart = 1'b1;
          end
        end
        default: restart = 1'b1;
      endcase
      if (restart) open_token(b, cur, nxt);
      if (b == CH_NL) begin
        if (line_cnt != {LN_W{1'b1}}) line_cnt++;
        col_cnt = LN_W'(1);
      end else if (col_cnt != {LN_W{1'b1}}) begin
        col_cnt++;
      end
      byte_pos = nxt;
    end
    if (run_n > 0) run_tok[run_n-1].last = 1'b1;
    for (int i = 0; i < run_n; i++) pending_tokens.insert(pending_tokens.size(), run_tok[i]);
  endtask

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("mismatch: %s", msg);
  endtask

  task automatic check_field(input string what, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s got %0h want %0h", results_seen, what,
                                got, want));
  endtask

  function automatic int source_gap(input pace_e p);
    case (p)
      PACE_SRC:  return 53;
      PACE_BOTH: return 23;
      default:   return 0;
    endcase
  endfunction

  function automatic int sink_stall(input pace_e p);
    case (p)
      PACE_SNK:  return 53;
      PACE_BOTH: return 23;
      default:   return 0;
    endcase
  endfunction

  // Stimulus builders
  task automatic put_byte(input logic [7:0] b);
    text_req_t r;
    r = '{eot: 1'b0, text: b, pace: gen_pace, hold: gen_hold};
    text_feed.insert(text_feed.size(), r);
    gen_hold = 1'b0;
    gen_count++;
  endtask

  task automatic put_eot();
    text_req_t r;
    r = '{eot: 1'b1, text: 8'($urandom_range(0, 255)), pace: gen_pace, hold: gen_hold};
    text_feed.insert(text_feed.size(), r);
    gen_hold = 1'b0;
    gen_count++;
  endtask

  task automatic put_str(input string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endtask

  function automatic logic [7:0] rand_digit();
    return CH_ZERO + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] rand_lead();
    int r;
    r = $urandom_range(0, 52);
    if (r < 26) return CH_LO_A + 8'(r);
    if (r < 52) return CH_UP_A + 8'(r - 26);
    return CH_UNDER;
  endfunction

  function automatic logic [7:0] rand_blank(input logic with_nl);
    logic [7:0] b;
    b = (4'($urandom_range(0, 5)) == 0) ? CH_SPACE : 8'($urandom_range(9, 13));
    if (!with_nl && b == CH_NL) b = CH_SPACE;
    return b;
  endfunction

  task automatic gen_ident();
    put_byte(rand_lead());
    repeat ($urandom_range(0, 6))
      put_byte(($urandom_range(0, 3) == 0) ? rand_digit() : rand_lead());
  endtask

  task automatic gen_number();
    if ($urandom_range(0, 3) == 0) put_byte(CH_DOT);
    put_byte(rand_digit());
    repeat ($urandom_range(0, 3))
      put_byte(($urandom_range(0, 4) == 0) ? CH_DOT : rand_digit());
    if ($urandom_range(0, 2) == 0) begin
      put_byte($urandom_range(0, 1) ? CH_LO_E : CH_UP_E);
      case ($urandom_range(0, 2))
        0: put_byte(CH_PLUS);
        1: put_byte(CH_MINUS);
        default: ;
      endcase
      repeat ($urandom_range(0, 2)) put_byte(rand_digit());
    end
  endtask

  task automatic gen_string();
    logic [7:0] q;
    logic [7:0] c;
    q = $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
    put_byte(q);
    repeat ($urandom_range(0, 6)) begin
      case ($urandom_range(0, 5))
        0: begin
          put_byte(q);
          put_byte(q);
        end
        1: begin
          put_byte(CH_BSLASH);
          put_byte(8'($urandom_range(0, 255)));
        end
        2: put_byte((q == CH_SQUOTE) ? CH_DQUOTE : CH_SQUOTE);
        default: begin
          c = 8'($urandom_range(32, 126));
          put_byte((c == q || c == CH_BSLASH) ? CH_LO_A : c);
        end
      endcase
    end
    put_byte(q);
  endtask

  task automatic gen_comment();
    logic [7:0] c;
    put_byte(CH_SLASH);
    put_byte(CH_SLASH);
    repeat ($urandom_range(0, 8)) begin
      c = 8'($urandom_range(0, 255));
      put_byte((c == CH_NL) ? CH_LO_A : c);
    end
    put_byte(CH_NL);
  endtask

  task automatic gen_op();
    string pairs_s;
    string singles_s;
    int    k;
    pairs_s   = "<=<><-<<>=>>!=||->";
    singles_s = "<>!|-";
    if ($urandom_range(0, 9) < 7) begin
      k = 2 * $urandom_range(0, 8);
      put_byte(pairs_s[k]);
      put_byte(pairs_s[k+1]);
    end else begin
      put_byte(singles_s[$urandom_range(0, 4)]);
    end
  endtask

  task automatic gen_token();
    string punct_s;
    int    r;
    punct_s = "{}[](),:;";
    r = $urandom_range(0, 99);
    if (r < 18) gen_ident();
    else if (r < 32) gen_number();
    else if (r < 44) gen_string();
    else if (r < 50) gen_comment();
    else if (r < 62) gen_op();
    else if (r < 72) put_byte(punct_s[$urandom_range(0, 8)]);
    else if (r < 85) repeat ($urandom_range(1, 3)) put_byte(rand_blank(1'b1));
    else put_byte(8'($urandom_range(0, 255)));
    if ($urandom_range(0, 1) == 0) put_byte(rand_blank(1'b1));
  endtask

  task automatic build_text();
    int base;
    int blk;
    int last_blk;
    gen_pace = PACE_FREE;
    put_str("x_9 1.5E+7 .2<=a//c\n'a''\\''");
    put_byte(8'h80);
    put_byte(8'hff);
    put_byte(8'h00);
    put_str("q<-7");
    put_byte(CH_NL);
    base     = gen_count;
    last_blk = -1;
    while (gen_count - base < 640) begin
      blk = (gen_count - base) / 80;
      if (blk != last_blk) begin
        gen_pace = pace_e'(blk % 4);
        gen_hold = 1'b1;
        last_blk = blk;
      end
      gen_token();
    end
    gen_pace = PACE_BOTH;
    base = gen_count;
    while (gen_count - base < 60) gen_token();
    put_byte(CH_NL);
    case ($urandom_range(0, 7))
      0: put_str("'ab");
      1: put_str("\"x\\");
      2: put_str("abc");
      3: put_str("7e");
      4: put_byte(CH_LT);
      5: put_str("'z'");
      6: put_byte(CH_SLASH);
      default: put_byte(CH_DOT);
    endcase
    put_eot();
    repeat (3) put_byte(8'($urandom_range(0, 255)));
    put_eot();
  endtask

  initial begin
    scan_ph   = PH_IDLE;
    held_b    = 8'h00;
    tok_begin = '0;
    tok_line  = LN_W'(1);
    tok_col   = LN_W'(1);
    byte_pos  = '0;
    line_cnt  = LN_W'(1);
    col_cnt   = LN_W'(1);
    text_done = 1'b0;
    build_text();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    while (text_feed.size() != 0 || in_valid) @(posedge clk);
    while (pending_tokens.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (mismatches == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("status: fail");
    $finish;
  end

  always @(posedge clk) begin : feed_drv
    logic      go;
    text_req_t head;
    go = in_valid;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        tokenize_byte(mode_r, byte_r);
        go = 1'b0;
      end
      // hold a flagged request until all outstanding tokens drain
      if (!go && text_feed.size() != 0) begin
        if (!(text_feed[0].hold && pending_tokens.size() != 0) &&
            $urandom_range(0, 99) >= source_gap(text_feed[0].pace)) begin
          head = text_feed.pop_front();
          mode_r   <= head.eot;
          byte_r   <= head.text;
          cur_pace <= head.pace;
          go = 1'b1;
        end
      end
      in_valid <= go;
    end else begin
      in_valid <= 1'b0;
    end
  end

  always @(posedge clk) begin : result_mon
    token_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_tokens.size() == 0) begin
          report_mismatch($sformatf("unexpected token kind %0d at offset %0d", token_kind,
                                    start_offset));
        end else begin
          want = pending_tokens.pop_front();
          check_field("kind", token_kind, want.kind);
          check_field("start_offset", start_offset, want.s_off);
          check_field("end_offset", end_offset, want.e_off);
          check_field("start_line", start_line, want.line);
          check_field("start_column", start_column, want.col);
          check_field("last_of_run", last_of_run, want.last);
        end
        results_seen++;
      end
      out_ready <= ($urandom_range(0, 99) >= sink_stall(cur_pace));
    end
  end

endmodule
